FILE: design/sbet_pkg.sv
`timescale 1ns / 1ps

package sbet_pkg;

  localparam int TIME_W  = 48;
  localparam int PORT_W  = 6;
  localparam int VLAN_W  = 12;
  localparam int MAC_W   = 48;
  localparam int DELAY_W = 32;
  localparam int CODE_W  = 2;

  localparam int MS_PER_SEC         = 1000;
  localparam int DEFAULT_DELAY_SECS = 30;
  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(DEFAULT_DELAY_SECS * MS_PER_SEC);

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

  localparam logic KIND_NEW_ADDR = 1'b0;
  localparam logic KIND_MOVED    = 1'b1;

  localparam logic CFG_NA_DELAY    = 1'b0;
  localparam logic CFG_MOVED_DELAY = 1'b1;

  typedef enum logic [1:0] {
    ACT_NOTIFY  = 2'd0,
    ACT_BLOCK   = 2'd1,
    ACT_UNBLOCK = 2'd2
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_NOT_IN_VLAN = 2'd0,
    CODE_NEW_ADDR    = 2'd1,
    CODE_MOVED       = 2'd2,
    CODE_OTHER       = 2'd3
  } breach_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_CMP,
    ST_EV_NOTE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    action_t            action;
    logic               kind;
    logic [PORT_W-1:0]  port;
    logic [VLAN_W-1:0]  vlan;
    logic [MAC_W-1:0]   mac;
  } res_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic in_sweep;
    logic in_event_ok;
    logic is_moved;
    logic fdb_hit;
    logic expired;
    logic sw_hit;
    logic pend_v;
    logic out_free;
  } stat_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic mem_re;
    logic sweep_addr;
    logic ev_act;
    logic ev_note;
    logic sw_take;
    logic flush;
  } ctrl_t;

endpackage

FILE: design/sbet_stamp_ram.sv
`timescale 1ns / 1ps

module sbet_stamp_ram import sbet_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [TIME_W-1:0] rdata,
  output logic              rvalid,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [TIME_W-1:0] wdata
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [TIME_W-1:0] rdata_r;
  logic              rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // entries never written read back with rvalid low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= vld_r[raddr];
      end
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvalid_r;

endmodule

FILE: design/sbet_expiry.sv
`timescale 1ns / 1ps

module sbet_expiry import sbet_pkg::*; (
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [TIME_W-1:0]  stamp,
  input  logic [DELAY_W-1:0] delay_ms,
  output logic               expired
);

  logic [TIME_W:0] limit;

  // full-width sum, never wraps
  assign limit   = {1'b0, stamp} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_ms};
  assign expired = ({1'b0, now_ms} > limit);

endmodule

FILE: design/sbet_seq.sv
`timescale 1ns / 1ps

module sbet_seq import sbet_pkg::*; #(
  parameter int NUM_PORTS = 32,
  parameter int AW        = 5,
  parameter int CW        = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stat_t         stat,
  output ctrl_t         ctrl,
  output logic [CW-1:0] rd_idx,
  output logic [AW-1:0] cmp_idx,
  output logic          cmp_v
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          accept;
  logic          stall;
  logic          rd_more;
  logic          sweep_done;

  assign accept     = stat.in_valid && (state_r == ST_IDLE);
  assign stall      = stat.sw_hit && stat.pend_v && !stat.out_free;
  assign rd_more    = (rd_idx_r < CW'(NUM_PORTS));
  assign sweep_done = !rd_more && !cmp_v_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (stat.in_sweep) begin
            state_nxt = ST_SWEEP;
          end else if (stat.in_event_ok) begin
            state_nxt = ST_EV_CMP;
          end
        end
      end
      ST_EV_CMP: begin
        if (stat.expired) begin
          state_nxt = (!stat.is_moved && !stat.fdb_hit) ? ST_EV_NOTE : ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EV_NOTE: begin
        if (stat.out_free) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_v || stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.mem_re   = accept;
      end
      ST_EV_CMP: begin
        ctrl.ev_act = stat.expired;
      end
      ST_EV_NOTE: begin
        ctrl.ev_note = stat.out_free;
      end
      ST_SWEEP: begin
        ctrl.sweep_addr = 1'b1;
        ctrl.mem_re     = rd_more && !stall;
        ctrl.sw_take    = stat.sw_hit && !stall;
      end
      ST_FLUSH: begin
        ctrl.flush = stat.pend_v && stat.out_free;
      end
      default: ctrl = '0;
    endcase
  end

  // sweep pipeline: read one port while comparing the previous one
  always_comb begin
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_v_nxt   = cmp_v_r;
    if (state_r == ST_IDLE) begin
      rd_idx_nxt = '0;
      cmp_v_nxt  = 1'b0;
    end else if (state_r == ST_SWEEP && !stall) begin
      cmp_v_nxt = rd_more;
      if (rd_more) begin
        cmp_idx_nxt = rd_idx_r[AW-1:0];
        rd_idx_nxt  = rd_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      cmp_idx_r <= '0;
      cmp_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      cmp_v_r   <= cmp_v_nxt;
    end
  end

  assign rd_idx  = rd_idx_r;
  assign cmp_idx = cmp_idx_r;
  assign cmp_v   = cmp_v_r;

endmodule

FILE: design/security_breach_event_throttle_unit.sv
`timescale 1ns / 1ps

// Per-port holdoff for switch security-breach events. A dropped breach event
// leaves the sequencer idle; a throttled one goes through the compare and back
// to idle; one that produces results goes through the stamp read and compare,
// then hands each result to the output register in turn. During a sweep the
// new-address stamp memory is read one port per cycle while no output stall
// holds it, and its data is checked by the single shared add-and-compare unit
// in the next cycle. Results for an item are held one deep, so the last flag
// is known before a result leaves. in_ready is high whenever the sequencer is
// idle, even while a finished result still waits in the output register.
// Stamps start at zero after reset without any clearing pass.
module security_breach_event_throttle_unit import sbet_pkg::*; #(
  parameter int NUM_PORTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic [PORT_W-1:0]  in_port_num,
  input  logic [CODE_W-1:0]  in_breach_code,
  input  logic [VLAN_W-1:0]  in_vlan_id,
  input  logic [MAC_W-1:0]   in_src_mac,
  input  logic               in_fdb_hit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic               out_breach_kind,
  output logic [PORT_W-1:0]  out_port,
  output logic [VLAN_W-1:0]  out_vlan,
  output logic [MAC_W-1:0]   out_mac,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DELAY_W-1:0] cfg_data
);

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CW = $clog2(NUM_PORTS + 1);

  stat_t stat;
  ctrl_t ctrl;

  logic [CW-1:0] rd_idx;
  logic [AW-1:0] cmp_idx;
  logic          cmp_v;
  logic          accept;

  logic [DELAY_W-1:0] na_delay_r, mv_delay_r;

  logic               cap_req_r;
  logic [TIME_W-1:0]  cap_now_r;
  logic [PORT_W-1:0]  cap_port_r;
  logic [CODE_W-1:0]  cap_code_r;
  logic [VLAN_W-1:0]  cap_vlan_r;
  logic [MAC_W-1:0]   cap_mac_r;
  logic               cap_hit_r;
  logic [AW-1:0]      cap_idx;
  logic               cap_moved;

  logic [AW-1:0]      raddr;
  logic [TIME_W-1:0]  na_rdata, mv_rdata;
  logic               na_rvld, mv_rvld;
  logic [TIME_W-1:0]  na_stamp, mv_stamp;
  logic [TIME_W-1:0]  cmp_stamp;
  logic [DELAY_W-1:0] cmp_delay;
  logic               expired;

  logic [NUM_PORTS-1:0] blocked_r, blocked_nxt;
  logic                 sw_hit;

  logic  pend_v_r, pend_v_nxt;
  res_t  pend_r, pend_nxt;
  logic  out_v_r, out_v_nxt;
  res_t  out_r, out_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_free;
  res_t  ev_first, na_note, unblock_res;

  assign accept = in_valid && ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      na_delay_r <= DELAY_RESET;
      mv_delay_r <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NA_DELAY:    na_delay_r <= cfg_data;
        CFG_MOVED_DELAY: mv_delay_r <= cfg_data;
        default:         na_delay_r <= na_delay_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_req_r  <= in_req_type;
      cap_now_r  <= in_now_ms;
      cap_port_r <= in_port_num;
      cap_code_r <= in_breach_code;
      cap_vlan_r <= in_vlan_id;
      cap_mac_r  <= in_src_mac;
      cap_hit_r  <= in_fdb_hit;
    end
  end

  assign cap_idx   = AW'(cap_port_r - PORT_W'(1));
  assign cap_moved = (cap_req_r == REQ_EVENT) && (cap_code_r == CODE_MOVED);

  assign raddr = ctrl.sweep_addr ? rd_idx[AW-1:0] : AW'(in_port_num - PORT_W'(1));

  sbet_stamp_ram #(.DEPTH(NUM_PORTS), .AW(AW)) u_na_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .re     (ctrl.mem_re),
    .raddr  (raddr),
    .rdata  (na_rdata),
    .rvalid (na_rvld),
    .we     (ctrl.ev_act && !cap_moved),
    .waddr  (cap_idx),
    .wdata  (cap_now_r)
  );

  sbet_stamp_ram #(.DEPTH(NUM_PORTS), .AW(AW)) u_mv_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .re     (ctrl.mem_re),
    .raddr  (raddr),
    .rdata  (mv_rdata),
    .rvalid (mv_rvld),
    .we     (ctrl.ev_act && cap_moved),
    .waddr  (cap_idx),
    .wdata  (cap_now_r)
  );

  assign na_stamp  = na_rvld ? na_rdata : '0;
  assign mv_stamp  = mv_rvld ? mv_rdata : '0;
  assign cmp_stamp = cap_moved ? mv_stamp : na_stamp;
  assign cmp_delay = cap_moved ? mv_delay_r : na_delay_r;

  sbet_expiry u_expiry (
    .now_ms   (cap_now_r),
    .stamp    (cmp_stamp),
    .delay_ms (cmp_delay),
    .expired  (expired)
  );

  assign sw_hit = cmp_v && blocked_r[cmp_idx] && expired;

  always_comb begin
    blocked_nxt = blocked_r;
    if (ctrl.ev_act && !cap_moved) begin
      blocked_nxt[cap_idx] = 1'b1;
    end
    if (ctrl.sw_take) begin
      blocked_nxt[cmp_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r <= '0;
    end else begin
      blocked_r <= blocked_nxt;
    end
  end

  assign out_free = !out_v_r || out_ready;

  assign stat.in_valid    = in_valid;
  assign stat.in_sweep    = (in_req_type == REQ_SWEEP);
  assign stat.in_event_ok = (in_port_num != '0)
                            && ({1'b0, in_port_num} <= (PORT_W + 1)'(NUM_PORTS))
                            && ((in_breach_code == CODE_NEW_ADDR)
                                || (in_breach_code == CODE_MOVED));
  assign stat.is_moved    = cap_moved;
  assign stat.fdb_hit     = cap_hit_r;
  assign stat.expired     = expired;
  assign stat.sw_hit      = sw_hit;
  assign stat.pend_v      = pend_v_r;
  assign stat.out_free    = out_free;

  sbet_seq #(.NUM_PORTS(NUM_PORTS), .AW(AW), .CW(CW)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .ctrl    (ctrl),
    .rd_idx  (rd_idx),
    .cmp_idx (cmp_idx),
    .cmp_v   (cmp_v)
  );

  always_comb begin
    ev_first = '{action: ACT_BLOCK, kind: KIND_NEW_ADDR, port: cap_port_r,
                 vlan: '0, mac: '0};
    if (cap_moved) begin
      ev_first = '{action: ACT_NOTIFY, kind: KIND_MOVED, port: cap_port_r,
                   vlan: cap_vlan_r, mac: cap_mac_r};
    end
    na_note     = '{action: ACT_NOTIFY, kind: KIND_NEW_ADDR, port: cap_port_r,
                    vlan: cap_vlan_r, mac: cap_mac_r};
    unblock_res = '{action: ACT_UNBLOCK, kind: KIND_NEW_ADDR,
                    port: PORT_W'(cmp_idx) + PORT_W'(1), vlan: '0, mac: '0};
  end

  // hold one result back so the last flag is known when it leaves
  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (ctrl.ev_act) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = ev_first;
    end
    if (ctrl.ev_note) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_r;
      out_last_nxt = 1'b0;
      pend_nxt     = na_note;
    end
    if (ctrl.sw_take) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = unblock_res;
    end
    if (ctrl.flush) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready        = ctrl.in_ready;
  assign out_valid       = out_v_r;
  assign out_action      = out_r.action;
  assign out_breach_kind = out_r.kind;
  assign out_port        = out_r.port;
  assign out_vlan        = out_r.vlan;
  assign out_mac         = out_r.mac;
  assign out_last        = out_last_r;

endmodule

FILE: design/sbet_checker.sv
`timescale 1ns / 1ps

module sbet_checker import sbet_pkg::*; #(
  parameter int NUM_PORTS = 32
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_action,
  input logic               out_breach_kind,
  input logic [PORT_W-1:0]  out_port,
  input logic [VLAN_W-1:0]  out_vlan,
  input logic [MAC_W-1:0]   out_mac,
  input logic               out_last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_port)
      && $stable(out_mac) && $stable(out_last))
    else $error("output transaction changed while stalled");

  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_SWEEP) |=> !in_ready)
    else $error("sweep did not hold off the input");

  a_unblock_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_UNBLOCK || out_action == ACT_BLOCK)
      |-> out_vlan == '0 && out_mac == '0 && out_breach_kind == KIND_NEW_ADDR)
    else $error("block or unblock carries notification data");

  a_port_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_port != '0 && {1'b0, out_port} <= (PORT_W + 1)'(NUM_PORTS))
    else $error("result port out of range");

endmodule

bind security_breach_event_throttle_unit sbet_checker #(.NUM_PORTS(NUM_PORTS)) u_sbet_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_action      (out_action),
  .out_breach_kind (out_breach_kind),
  .out_port        (out_port),
  .out_vlan        (out_vlan),
  .out_mac         (out_mac),
  .out_last        (out_last)
);
